// ----- rtl/tws_pkg.sv -----
// shared types and constants of the timing wheel scheduler
package tws_pkg;

	localparam int unsigned SLOT_W  = 10;
	localparam int unsigned ROUND_W = 32;
	localparam int unsigned DELAY_W = 24;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TICKS_W = 25;

	localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 2'd3;

	localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 11'd64;
	localparam logic [CNT_W-1:0] SLOT_COUNT_MAX   = 11'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_DIV,
		ST_SCAN,
		ST_OUT,
		ST_ADVANCE
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic                start;
		logic [TICKS_W-1:0]  dividend;
		logic [CNT_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [TICKS_W-1:0]  quotient;
		logic [CNT_W-1:0]    remainder;
	} div_rsp_t;

endpackage

// ----- rtl/tws_divider.sv -----
// shared restoring divider, one quotient bit per cycle
module tws_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  tws_pkg::div_req_t req,
	output tws_pkg::div_rsp_t rsp
);

	localparam int unsigned STEP_W = $clog2(tws_pkg::TICKS_W + 1);

	logic [tws_pkg::TICKS_W-1:0] quo_q;
	logic [tws_pkg::CNT_W-1:0]   rem_q;
	logic [tws_pkg::CNT_W-1:0]   dsr_q;
	logic [STEP_W-1:0]           step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tws_pkg::CNT_W:0]     trial;
	logic [tws_pkg::CNT_W:0]     diff;

	assign trial = {rem_q, quo_q[tws_pkg::TICKS_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(tws_pkg::TICKS_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below divisor, so it fits cnt_w bits
			if (!diff[tws_pkg::CNT_W]) begin
				rem_q <= diff[tws_pkg::CNT_W-1:0];
				quo_q <= {quo_q[tws_pkg::TICKS_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[tws_pkg::CNT_W-1:0];
				quo_q <= {quo_q[tws_pkg::TICKS_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- rtl/timing_wheel_scheduler_core.sv -----
// Timing wheel scheduler: a register command gets its answer from the entry search and keeps the
// block busy from transfer to the next command (an entry search and, if an entry is free, a serial
// division of the slot offset by the slot count and a write-back). A tick command walks the event
// store one entry per cycle; every entry that fires waits for its result transfer, and a recurrent
// one is rescheduled through the same divider. The block takes one command at a time; stall is
// high while a command is in progress. The store's valid bits clear at reset.
module timing_wheel_scheduler_core #(
	parameter int unsigned EVENT_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] event_id,
	input  logic [23:0] delay_ticks,
	input  logic        recurrent,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] fired_event_id,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned IDX_W = $clog2(EVENT_ENTRIES);
	localparam logic [2:0]  ADDR_SLOT_COUNT = 3'd0;

	tws_pkg::state_t state_q, state_d;

	logic [tws_pkg::CNT_W-1:0]   slot_count_q;
	logic [tws_pkg::SLOT_W-1:0]  cur_slot_q;
	logic [tws_pkg::ROUND_W-1:0] cur_rot_q;

	logic [EVENT_ENTRIES-1:0]    valid_q;
	logic [tws_pkg::ID_W-1:0]    ent_id_q    [EVENT_ENTRIES];
	logic [tws_pkg::ROUND_W-1:0] ent_round_q [EVENT_ENTRIES];
	logic [tws_pkg::SLOT_W-1:0]  ent_slot_q  [EVENT_ENTRIES];
	logic [tws_pkg::DELAY_W-1:0] ent_ivl_q   [EVENT_ENTRIES];
	logic                        ent_rep_q   [EVENT_ENTRIES];

	logic                        cmd_q;
	logic [tws_pkg::ID_W-1:0]    id_q;
	logic [tws_pkg::DELAY_W-1:0] delay_q;
	logic                        rec_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        resched_q;

	logic                        ov_q;
	logic [tws_pkg::KIND_W-1:0]  kind_q;
	logic [tws_pkg::ID_W-1:0]    fid_q;
	logic                        last_q;

	logic [tws_pkg::CNT_W-1:0]   eff_cnt;
	logic                        in_xfer, out_xfer, cfg_wr;
	logic                        found;
	logic [IDX_W-1:0]            free_idx;
	logic                        hit;
	logic                        scan_end;
	logic [tws_pkg::DELAY_W-1:0] ivl_use;
	logic [tws_pkg::SLOT_W:0]    slot_inc;

	tws_pkg::div_req_t div_req;
	tws_pkg::div_rsp_t div_rsp;

	tws_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (slot_count_q == '0)
			eff_cnt = tws_pkg::CNT_W'(1);
		else if (slot_count_q > tws_pkg::SLOT_COUNT_MAX)
			eff_cnt = tws_pkg::SLOT_COUNT_MAX;
		else
			eff_cnt = slot_count_q;
	end

	assign in_stall = (state_q != tws_pkg::ST_IDLE) || ov_q;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = ov_q && !out_stall;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign prdata   = (paddr == ADDR_SLOT_COUNT) ? {21'd0, slot_count_q} : 32'd0;

	// lowest free entry
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = EVENT_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				found    = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit = valid_q[idx_q] && ent_round_q[idx_q] == cur_rot_q
		&& ent_slot_q[idx_q] == cur_slot_q;
	assign scan_end = (idx_q == IDX_W'(EVENT_ENTRIES - 1));
	assign ivl_use  = (ent_ivl_q[idx_q] == '0) ? tws_pkg::DELAY_W'(1) : ent_ivl_q[idx_q];
	assign slot_inc = {1'b0, cur_slot_q} + 1'b1;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.divisor  = eff_cnt;
		div_req.dividend = tws_pkg::TICKS_W'(cur_slot_q) + tws_pkg::TICKS_W'(delay_q);
		if (state_q == tws_pkg::ST_FIND && found)
			div_req.start = 1'b1;
		if (state_q == tws_pkg::ST_OUT && out_xfer && resched_q) begin
			div_req.start    = 1'b1;
			div_req.dividend = tws_pkg::TICKS_W'(cur_slot_q) + tws_pkg::TICKS_W'(ivl_use);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tws_pkg::ST_IDLE:
				if (in_xfer) state_d = command ? tws_pkg::ST_SCAN : tws_pkg::ST_FIND;
			tws_pkg::ST_FIND:
				state_d = found ? tws_pkg::ST_DIV : tws_pkg::ST_IDLE;
			tws_pkg::ST_DIV:
				if (div_rsp.done) begin
					if (!cmd_q) state_d = tws_pkg::ST_IDLE;
					else if (scan_end) state_d = tws_pkg::ST_ADVANCE;
					else state_d = tws_pkg::ST_SCAN;
				end
			tws_pkg::ST_SCAN:
				if (!ov_q) begin
					if (hit) state_d = tws_pkg::ST_OUT;
					else if (scan_end) state_d = tws_pkg::ST_ADVANCE;
				end
			tws_pkg::ST_OUT:
				if (out_xfer) begin
					if (resched_q) state_d = tws_pkg::ST_DIV;
					else if (scan_end) state_d = tws_pkg::ST_ADVANCE;
					else state_d = tws_pkg::ST_SCAN;
				end
			tws_pkg::ST_ADVANCE:
				if (!ov_q) state_d = tws_pkg::ST_IDLE;
			default:
				state_d = tws_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tws_pkg::ST_IDLE;
			slot_count_q <= tws_pkg::SLOT_COUNT_RESET;
			cur_slot_q   <= '0;
			cur_rot_q    <= '0;
			valid_q      <= '0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr == ADDR_SLOT_COUNT)
				slot_count_q <= pwdata[tws_pkg::CNT_W-1:0];
			if (out_xfer && state_q != tws_pkg::ST_OUT)
				ov_q <= 1'b0;
			unique case (state_q)
				tws_pkg::ST_FIND: begin
					ov_q <= 1'b1;
					if (found) valid_q[free_idx] <= 1'b1;
				end
				tws_pkg::ST_SCAN:
					if (!ov_q && hit) ov_q <= 1'b1;
				tws_pkg::ST_OUT:
					if (out_xfer) begin
						ov_q <= 1'b0;
						if (!resched_q) valid_q[idx_q] <= 1'b0;
					end
				tws_pkg::ST_ADVANCE:
					if (!ov_q) begin
						ov_q <= 1'b1;
						if (slot_inc >= {1'b0, eff_cnt}) begin
							cur_slot_q <= '0;
							cur_rot_q  <= cur_rot_q + 1'b1;
						end else begin
							cur_slot_q <= slot_inc[tws_pkg::SLOT_W-1:0];
						end
					end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q   <= command;
			id_q    <= event_id;
			delay_q <= delay_ticks;
			rec_q   <= recurrent;
			idx_q   <= '0;
		end
		unique case (state_q)
			tws_pkg::ST_FIND: begin
				idx_q  <= free_idx;
				kind_q <= found ? tws_pkg::KIND_ACCEPTED : tws_pkg::KIND_REJECTED;
				fid_q  <= '0;
				last_q <= 1'b1;
				if (found) begin
					ent_id_q[free_idx]  <= id_q;
					ent_ivl_q[free_idx] <= delay_q;
					ent_rep_q[free_idx] <= rec_q;
				end
			end
			tws_pkg::ST_DIV:
				if (div_rsp.done) begin
					ent_round_q[idx_q] <= cur_rot_q + tws_pkg::ROUND_W'(div_rsp.quotient);
					ent_slot_q[idx_q]  <= div_rsp.remainder[tws_pkg::SLOT_W-1:0];
					if (cmd_q && !scan_end) begin
						idx_q   <= idx_q + 1'b1;
					end
				end
			tws_pkg::ST_SCAN:
				if (!ov_q) begin
					if (hit) begin
						kind_q    <= tws_pkg::KIND_FIRED;
						fid_q     <= ent_id_q[idx_q];
						last_q    <= 1'b0;
						resched_q <= ent_rep_q[idx_q];
					end else if (!scan_end) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			tws_pkg::ST_OUT:
				if (out_xfer && !resched_q && !scan_end) idx_q <= idx_q + 1'b1;
			tws_pkg::ST_ADVANCE:
				if (!ov_q) begin
					kind_q <= tws_pkg::KIND_TICK_DONE;
					fid_q  <= '0;
					last_q <= 1'b1;
				end
			default: ;
		endcase
	end

	// after a reschedule the scan resumes at the next entry, or advances after the last one
	assign out_valid      = ov_q;
	assign kind           = kind_q;
	assign fired_event_id = fid_q;
	assign last           = last_q;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tws_pkg::ST_IDLE) |-> !in_xfer)
		else $error("command accepted while busy");
	a_divider_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");
	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == tws_pkg::KIND_FIRED) |-> !last_q)
		else $error("fired result marked last");
	a_reject_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tws_pkg::ST_FIND && !found) |-> (valid_q == '1))
		else $error("rejected with a free entry");
`endif

endmodule
